@@ src/vpsp_pkg.sv @@
package vpsp_pkg;

  typedef enum logic [1:0] {
    KIND_SEQ     = 2'd0,
    KIND_HEADER  = 2'd1,
    KIND_PAYLOAD = 2'd2,
    KIND_SUMMARY = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    STOP_ENDED   = 2'd0,
    STOP_ZERO    = 2'd1,
    STOP_OVERRUN = 2'd2,
    STOP_LIMIT   = 2'd3
  } stop_t;

  typedef enum logic [3:0] {
    PH_SEQ  = 4'b0001,
    PH_HDR  = 4'b0010,
    PH_DATA = 4'b0100,
    PH_STOP = 4'b1000
  } phase_t;

  localparam int unsigned HDR_BYTES = 6;

  typedef struct packed {
    kind_t       kind;
    logic [15:0] seq_number;
    logic [15:0] segment_length;
    logic        field_flag;
    logic [14:0] row_number;
    logic        continuation;
    logic [14:0] pixel_offset;
    logic [7:0]  payload_byte;
    logic        segment_end;
    logic [3:0]  segment_count;
    stop_t       stop_cause;
    logic        final_res;
  } result_t;

endpackage

@@ src/vpsp_parser.sv @@
module vpsp_parser #(
  parameter int MAX_SEGMENTS = 12
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              advance,
  input  logic [7:0]        in_byte,
  input  logic [15:0]       packet_length,
  input  logic              packet_last,
  output vpsp_pkg::result_t res0,
  output vpsp_pkg::result_t res1,
  output logic [1:0]        res_cnt
);
  import vpsp_pkg::*;

  localparam logic [3:0] SEG_LIMIT = 4'(MAX_SEGMENTS);

  phase_t      phase_r, phase_nxt;
  logic [15:0] pos_r, pos_nxt;
  logic [2:0]  hidx_r, hidx_nxt;
  logic [31:0] shift_r, shift_nxt;
  logic [15:0] remain_r, remain_nxt;
  logic [3:0]  segs_r, segs_nxt;
  stop_t       stop_r, stop_nxt;

  logic [31:0] sh_new;
  logic [15:0] hdr_len;
  logic [15:0] start_pos;
  logic [17:0] seg_extent;
  logic        data_end;
  logic        own_valid;
  result_t     own_res;
  result_t     sum_res;

  assign sh_new     = {shift_r[23:0], in_byte};
  assign hdr_len    = sh_new[15:0];
  assign start_pos  = (pos_r != 16'd0) ? pos_r - 16'd1 : 16'd0;
  assign seg_extent = 18'(start_pos) + 18'(HDR_BYTES) + 18'(hdr_len);
  assign data_end   = (remain_r <= 16'd1);

  always_comb begin
    phase_nxt  = phase_r;
    pos_nxt    = pos_r;
    hidx_nxt   = hidx_r;
    shift_nxt  = shift_r;
    remain_nxt = remain_r;
    segs_nxt   = segs_r;
    stop_nxt   = stop_r;
    own_valid  = 1'b0;
    own_res    = '0;
    sum_res    = '0;

    if (advance) begin
      unique case (phase_r)
        PH_SEQ: begin
          shift_nxt = sh_new;
          if (pos_r != 16'd0) begin
            own_valid          = 1'b1;
            own_res.kind       = KIND_SEQ;
            own_res.seq_number = sh_new[15:0];
            phase_nxt          = PH_HDR;
            hidx_nxt           = '0;
            shift_nxt          = '0;
          end
        end
        PH_HDR: begin
          shift_nxt = sh_new;
          if (hidx_r == 3'd1) begin
            if (hdr_len == 16'd0) begin
              stop_nxt  = STOP_ZERO;
              phase_nxt = PH_STOP;
            end else if (seg_extent > 18'(packet_length)) begin
              stop_nxt  = STOP_OVERRUN;
              phase_nxt = PH_STOP;
            end else begin
              remain_nxt = hdr_len;
              hidx_nxt   = 3'd2;
            end
          end else if (hidx_r >= 3'd5) begin
            segs_nxt               = segs_r + 4'd1;
            own_valid              = 1'b1;
            own_res.kind           = KIND_HEADER;
            own_res.segment_length = remain_r;
            own_res.field_flag     = sh_new[31];
            own_res.row_number     = sh_new[30:16];
            own_res.continuation   = sh_new[15];
            own_res.pixel_offset   = sh_new[14:0];
            phase_nxt              = PH_DATA;
            hidx_nxt               = '0;
            shift_nxt              = '0;
          end else begin
            hidx_nxt = hidx_r + 3'd1;
          end
        end
        PH_DATA: begin
          remain_nxt           = data_end ? 16'd0 : remain_r - 16'd1;
          own_valid            = 1'b1;
          own_res.kind         = KIND_PAYLOAD;
          own_res.payload_byte = in_byte;
          own_res.segment_end  = data_end;
          if (data_end) begin
            if (segs_r >= SEG_LIMIT) begin
              stop_nxt  = STOP_LIMIT;
              phase_nxt = PH_STOP;
            end else begin
              phase_nxt = PH_HDR;
              hidx_nxt  = '0;
              shift_nxt = '0;
            end
          end
        end
        PH_STOP: ;
        default: ;
      endcase

      if (pos_r != 16'hFFFF) pos_nxt = pos_r + 16'd1;

      own_res.segment_count = segs_nxt;
      sum_res.kind          = KIND_SUMMARY;
      sum_res.segment_count = segs_nxt;
      sum_res.stop_cause    = stop_nxt;
      sum_res.final_res     = 1'b1;

      if (packet_last) begin
        phase_nxt  = PH_SEQ;
        pos_nxt    = '0;
        hidx_nxt   = '0;
        shift_nxt  = '0;
        remain_nxt = '0;
        segs_nxt   = '0;
        stop_nxt   = STOP_ENDED;
      end
    end
  end

  // Own result goes first; the summary follows it when both exist.
  always_comb begin
    res0 = own_valid ? own_res : sum_res;
    res1 = sum_res;
    res_cnt = 2'(own_valid) + 2'(advance & packet_last);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_SEQ;
      pos_r    <= '0;
      hidx_r   <= '0;
      shift_r  <= '0;
      remain_r <= '0;
      segs_r   <= '0;
      stop_r   <= STOP_ENDED;
    end else begin
      phase_r  <= phase_nxt;
      pos_r    <= pos_nxt;
      hidx_r   <= hidx_nxt;
      shift_r  <= shift_nxt;
      remain_r <= remain_nxt;
      segs_r   <= segs_nxt;
      stop_r   <= stop_nxt;
    end
  end

endmodule

@@ src/vpsp_result_fifo.sv @@
module vpsp_result_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  vpsp_pkg::result_t wr0,
  input  vpsp_pkg::result_t wr1,
  input  logic [1:0]        wr_cnt,
  output logic              room2,
  output logic              rd_valid,
  input  logic              rd_stall,
  output vpsp_pkg::result_t rd_data
);
  import vpsp_pkg::*;

  localparam int DEPTH = 4;

  result_t     mem_r [DEPTH];
  logic [1:0]  wp_r, wp_nxt;
  logic [1:0]  rp_r, rp_nxt;
  logic [2:0]  cnt_r, cnt_nxt;
  logic        pop;
  logic [1:0]  wp_plus1;

  assign rd_valid = (cnt_r != 3'd0);
  assign rd_data  = mem_r[rp_r];
  assign room2    = (cnt_r <= 3'(DEPTH - 2));
  assign pop      = rd_valid && !rd_stall;
  assign wp_plus1 = wp_r + 2'd1;

  always_comb begin
    wp_nxt  = wp_r + wr_cnt;
    rp_nxt  = pop ? rp_r + 2'd1 : rp_r;
    cnt_nxt = cnt_r + 3'(wr_cnt) - 3'(pop);
  end

  always_ff @(posedge clk) begin
    if (wr_cnt != 2'd0) mem_r[wp_r] <= wr0;
    if (wr_cnt == 2'd2) mem_r[wp_plus1] <= wr1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

@@ src/video_payload_segment_parser.sv @@
// Data path: the input register feeds the parser, whose results go into the result
// queue that drives the outputs. Throughput: one byte per cycle while the queue has
// room for two results; the closing byte of a packet can emit two results, so the
// four-entry result queue sets the pace when out_stall backs up.
// Reset (rst_n low, synchronous): parser returns to the sequence number phase
// with all per-packet state cleared, and the result queue empties.
module video_payload_segment_parser #(
  parameter int MAX_SEGMENTS = 12
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  input  logic [15:0] in_packet_length,
  input  logic        in_packet_last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_kind,
  output logic [15:0] out_seq_number,
  output logic [15:0] out_segment_length,
  output logic        out_field_flag,
  output logic [14:0] out_row_number,
  output logic        out_continuation,
  output logic [14:0] out_pixel_offset,
  output logic [7:0]  out_payload_byte,
  output logic        out_segment_end,
  output logic [3:0]  out_segment_count,
  output logic [1:0]  out_stop_cause,
  output logic        out_final_res
);
  import vpsp_pkg::*;

  logic        valid_r;
  logic [7:0]  byte_r;
  logic [15:0] plen_r;
  logic        last_r;
  logic        room2;
  logic        advance;
  result_t     res0, res1, rd_data;
  logic [1:0]  res_cnt;

  assign advance  = valid_r && room2;
  assign in_stall = valid_r && !room2;

  // Hold the input register while the queue lacks room for two results.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (!in_stall) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      byte_r <= in_byte;
      plen_r <= in_packet_length;
      last_r <= in_packet_last;
    end
  end

  vpsp_parser #(.MAX_SEGMENTS(MAX_SEGMENTS)) u_parser (
    .clk           (clk),
    .rst_n         (rst_n),
    .advance       (advance),
    .in_byte       (byte_r),
    .packet_length (plen_r),
    .packet_last   (last_r),
    .res0          (res0),
    .res1          (res1),
    .res_cnt       (res_cnt)
  );

  vpsp_result_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr0      (res0),
    .wr1      (res1),
    .wr_cnt   (res_cnt),
    .room2    (room2),
    .rd_valid (out_valid),
    .rd_stall (out_stall),
    .rd_data  (rd_data)
  );

  assign out_kind           = rd_data.kind;
  assign out_seq_number     = rd_data.seq_number;
  assign out_segment_length = rd_data.segment_length;
  assign out_field_flag     = rd_data.field_flag;
  assign out_row_number     = rd_data.row_number;
  assign out_continuation   = rd_data.continuation;
  assign out_pixel_offset   = rd_data.pixel_offset;
  assign out_payload_byte   = rd_data.payload_byte;
  assign out_segment_end    = rd_data.segment_end;
  assign out_segment_count  = rd_data.segment_count;
  assign out_stop_cause     = rd_data.stop_cause;
  assign out_final_res      = rd_data.final_res;

endmodule

@@ tb/sv/vpsp_result_checker.sv @@
module vpsp_result_checker #(
  parameter int MAX_SEGMENTS = 12
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  in_byte,
  input  logic [15:0] in_packet_length,
  input  logic        in_packet_last,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [1:0]  out_kind,
  input  logic [15:0] out_seq_number,
  input  logic [15:0] out_segment_length,
  input  logic        out_field_flag,
  input  logic [14:0] out_row_number,
  input  logic        out_continuation,
  input  logic [14:0] out_pixel_offset,
  input  logic [7:0]  out_payload_byte,
  input  logic        out_segment_end,
  input  logic [3:0]  out_segment_count,
  input  logic [1:0]  out_stop_cause,
  input  logic        out_final_res,
  output int unsigned error_count,
  output int unsigned results_pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import vpsp_pkg::*;

  phase_t      parse_phase;
  logic [15:0] byte_pos;
  logic [2:0]  hdr_idx;
  logic [39:0] hdr_shift;
  logic [15:0] data_left;
  logic [3:0]  segs_seen;
  stop_t       stop_why;

  result_t     expected_results[$];
  int unsigned fail_count = 0;
  int unsigned pending_count = 0;
  int unsigned reports = 0;

  assign error_count = fail_count;
  assign results_pending = pending_count;

  function automatic void clear_packet();
    parse_phase = PH_SEQ;
    byte_pos = '0;
    hdr_idx = '0;
    hdr_shift = '0;
    data_left = '0;
    segs_seen = '0;
    stop_why = STOP_ENDED;
  endfunction

  function automatic result_t blank_result(kind_t k);
    result_t r;
    r = '0;
    r.kind = k;
    r.segment_count = segs_seen;
    return r;
  endfunction

  // Advance the parser by one byte and queue the results it produces.
  function automatic void parse_byte(logic [7:0] b, logic [15:0] plen, logic last);
    result_t     r;
    logic [15:0] len;
    int unsigned start;
    logic        seg_done;
    case (parse_phase)
      PH_SEQ: begin
        hdr_shift = {hdr_shift[31:0], b};
        if (byte_pos >= 16'd1) begin
          r = blank_result(KIND_SEQ);
          r.seq_number = hdr_shift[15:0];
          expected_results.push_back(r);
          parse_phase = PH_HDR;
          hdr_idx = '0;
          hdr_shift = '0;
        end
      end
      PH_HDR: begin
        hdr_shift = {hdr_shift[31:0], b};
        if (hdr_idx == 3'd1) begin
          len = hdr_shift[15:0];
          start = (byte_pos > 0) ? byte_pos - 1 : 0;
          if (len == 16'd0) begin
            stop_why = STOP_ZERO;
            parse_phase = PH_STOP;
          end else if (start + HDR_BYTES + len > plen) begin
            stop_why = STOP_OVERRUN;
            parse_phase = PH_STOP;
          end else begin
            data_left = len;
            hdr_idx = 3'd2;
          end
        end else if (hdr_idx >= 3'd5) begin
          segs_seen = segs_seen + 4'd1;
          r = blank_result(KIND_HEADER);
          r.segment_length = data_left;
          r.field_flag = hdr_shift[31];
          r.row_number = hdr_shift[30:16];
          r.continuation = hdr_shift[15];
          r.pixel_offset = hdr_shift[14:0];
          expected_results.push_back(r);
          parse_phase = PH_DATA;
          hdr_idx = '0;
          hdr_shift = '0;
        end else begin
          hdr_idx = hdr_idx + 3'd1;
        end
      end
      PH_DATA: begin
        seg_done = (data_left <= 16'd1);
        data_left = seg_done ? 16'd0 : data_left - 16'd1;
        r = blank_result(KIND_PAYLOAD);
        r.payload_byte = b;
        r.segment_end = seg_done;
        expected_results.push_back(r);
        if (seg_done) begin
          if (segs_seen >= MAX_SEGMENTS) begin
            stop_why = STOP_LIMIT;
            parse_phase = PH_STOP;
          end else begin
            parse_phase = PH_HDR;
            hdr_idx = '0;
            hdr_shift = '0;
          end
        end
      end
      default: ;
    endcase

    if (byte_pos != 16'hFFFF) byte_pos = byte_pos + 16'd1;

    if (last) begin
      r = blank_result(KIND_SUMMARY);
      r.stop_cause = stop_why;
      r.final_res = 1'b1;
      expected_results.push_back(r);
      clear_packet();
    end
  endfunction

  function automatic string diff_fields(result_t want, result_t got);
    string s;
    s = "";
    if (want.kind != got.kind) s = {s, " kind"};
    if (want.seq_number != got.seq_number) s = {s, " seq_number"};
    if (want.segment_length != got.segment_length) s = {s, " segment_length"};
    if (want.field_flag != got.field_flag) s = {s, " field_flag"};
    if (want.row_number != got.row_number) s = {s, " row_number"};
    if (want.continuation != got.continuation) s = {s, " continuation"};
    if (want.pixel_offset != got.pixel_offset) s = {s, " pixel_offset"};
    if (want.payload_byte != got.payload_byte) s = {s, " payload_byte"};
    if (want.segment_end != got.segment_end) s = {s, " segment_end"};
    if (want.segment_count != got.segment_count) s = {s, " segment_count"};
    if (want.stop_cause != got.stop_cause) s = {s, " stop_cause"};
    if (want.final_res != got.final_res) s = {s, " final_res"};
    return s;
  endfunction

  function automatic string show(result_t r);
    return $sformatf({"kind=%0d seq=%h len=%h f=%b row=%h c=%b off=%h ",
                      "byte=%h end=%b segs=%0d stop=%0d fin=%b"},
                     r.kind, r.seq_number, r.segment_length, r.field_flag, r.row_number,
                     r.continuation, r.pixel_offset, r.payload_byte, r.segment_end,
                     r.segment_count, r.stop_cause, r.final_res);
  endfunction

  always @(posedge clk) begin
    result_t got;
    result_t want;
    string   diffs;
    if (!rst_n) begin
      clear_packet();
      expected_results.delete();
    end else begin
      if (in_valid && !in_stall) parse_byte(in_byte, in_packet_length, in_packet_last);
      if (out_valid && !out_stall) begin
        got.kind = kind_t'(out_kind);
        got.seq_number = out_seq_number;
        got.segment_length = out_segment_length;
        got.field_flag = out_field_flag;
        got.row_number = out_row_number;
        got.continuation = out_continuation;
        got.pixel_offset = out_pixel_offset;
        got.payload_byte = out_payload_byte;
        got.segment_end = out_segment_end;
        got.segment_count = out_segment_count;
        got.stop_cause = stop_t'(out_stop_cause);
        got.final_res = out_final_res;
        if (expected_results.size() == 0) begin
          fail_count++;
          if (reports < 10) $display("%0t: unexpected result: %s", $realtime, show(got));
          reports++;
        end else begin
          want = expected_results.pop_front();
          diffs = diff_fields(want, got);
          if (diffs != "") begin
            fail_count++;
            if (reports < 10) begin
              $display("%0t: mismatch in%s", $realtime, diffs);
              $display("  expected %s", show(want));
              $display("  actual   %s", show(got));
            end
            reports++;
          end
        end
      end
    end
    pending_count = expected_results.size();
  end

endmodule

@@ tb/sv/tb_video_payload_segment_parser.sv @@
module tb_video_payload_segment_parser;
  timeunit 1ns;
  timeprecision 1ps;
  import vpsp_pkg::*;

  localparam int MAX_SEG = 12;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_byte = '0;
  logic [15:0] in_packet_length = '0;
  logic        in_packet_last = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_kind;
  logic [15:0] out_seq_number;
  logic [15:0] out_segment_length;
  logic        out_field_flag;
  logic [14:0] out_row_number;
  logic        out_continuation;
  logic [14:0] out_pixel_offset;
  logic [7:0]  out_payload_byte;
  logic        out_segment_end;
  logic [3:0]  out_segment_count;
  logic [1:0]  out_stop_cause;
  logic        out_final_res;

  int unsigned error_count;
  int unsigned results_pending;

  int          sender_idle_pct = 0;
  int          receiver_stall_pct = 0;
  int          hold_request = 0;
  int          hold_left = 0;
  int unsigned bytes_sent = 0;
  logic [7:0]  packet_bytes[$];

  video_payload_segment_parser #(
    .MAX_SEGMENTS(MAX_SEG)
  ) u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_byte           (in_byte),
    .in_packet_length  (in_packet_length),
    .in_packet_last    (in_packet_last),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_kind          (out_kind),
    .out_seq_number    (out_seq_number),
    .out_segment_length(out_segment_length),
    .out_field_flag    (out_field_flag),
    .out_row_number    (out_row_number),
    .out_continuation  (out_continuation),
    .out_pixel_offset  (out_pixel_offset),
    .out_payload_byte  (out_payload_byte),
    .out_segment_end   (out_segment_end),
    .out_segment_count (out_segment_count),
    .out_stop_cause    (out_stop_cause),
    .out_final_res     (out_final_res)
  );

  vpsp_result_checker #(
    .MAX_SEGMENTS(MAX_SEG)
  ) u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_byte           (in_byte),
    .in_packet_length  (in_packet_length),
    .in_packet_last    (in_packet_last),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_kind          (out_kind),
    .out_seq_number    (out_seq_number),
    .out_segment_length(out_segment_length),
    .out_field_flag    (out_field_flag),
    .out_row_number    (out_row_number),
    .out_continuation  (out_continuation),
    .out_pixel_offset  (out_pixel_offset),
    .out_payload_byte  (out_payload_byte),
    .out_segment_end   (out_segment_end),
    .out_segment_count (out_segment_count),
    .out_stop_cause    (out_stop_cause),
    .out_final_res     (out_final_res),
    .error_count       (error_count),
    .results_pending   (results_pending)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // Receiver: a requested hold-off overrides the random stalls.
  initial begin
    forever begin
      @(negedge clk);
      if (hold_request > 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(0, 99) < receiver_stall_pct);
      end
    end
  end

  // Call at a falling edge; returns at the falling edge after the item is taken.
  task automatic push_byte(input logic [7:0] b, input logic [15:0] plen, input logic last);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_byte <= b;
    in_packet_length <= plen;
    in_packet_last <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    bytes_sent++;
  endtask

  task automatic send_packet(input logic [15:0] plen);
    for (int i = 0; i < packet_bytes.size(); i++) begin
      push_byte(packet_bytes[i], plen, i == packet_bytes.size() - 1);
    end
  endtask

  // Mostly well-formed packets; some cut short, overrun, zero-length or plain noise.
  function automatic logic [15:0] build_random_packet();
    int          shape;
    int          nseg;
    int          len;
    int          total;
    int          cut;
    logic [15:0] plen;
    packet_bytes.delete();
    shape = $urandom_range(0, 9);
    if (shape == 0) begin
      repeat ($urandom_range(1, 24)) packet_bytes.push_back(8'($urandom));
      plen = 16'($urandom);
    end else begin
      repeat (2) packet_bytes.push_back(8'($urandom));
      nseg = (shape == 1) ? $urandom_range(MAX_SEG - 1, MAX_SEG + 1) : $urandom_range(1, 4);
      for (int s = 0; s < nseg; s++) begin
        if (shape == 1) len = $urandom_range(1, 2);
        else if ($urandom_range(0, 7) == 0) len = $urandom_range(7, 40);
        else len = $urandom_range(1, 6);
        if (shape == 2 && s == nseg - 1) len = 0;
        packet_bytes.push_back(8'(len >> 8));
        packet_bytes.push_back(8'(len));
        repeat (4) packet_bytes.push_back(8'($urandom));
        repeat (len) packet_bytes.push_back(8'($urandom));
      end
      total = packet_bytes.size();
      plen = 16'(total);
      case (shape)
        3: plen = 16'(total - $urandom_range(1, 8));
        4: begin
          cut = $urandom_range(1, 7);
          repeat (cut) packet_bytes.delete(packet_bytes.size() - 1);
        end
        5: plen = 16'(total + $urandom_range(0, 65535 - total));
        default: ;
      endcase
    end
    return plen;
  endfunction

  initial begin
    logic [15:0] plen;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    sender_idle_pct = 6;
    receiver_stall_pct = 65;

    // packet ends before the sequence number is complete
    packet_bytes = {8'hA5};
    send_packet(16'd1);
    // zero-length header, then an ignored byte
    packet_bytes = {8'hFF, 8'hFF, 8'h00, 8'h00, 8'h3C};
    send_packet(16'hFFFF);
    // segment would overrun the packet
    packet_bytes = {8'h00, 8'h00, 8'h00, 8'h05, 8'h81};
    send_packet(16'd10);
    // all header bits set, exact fit, packet ends on the data byte
    packet_bytes = {8'h12, 8'h34, 8'h00, 8'h01, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
    send_packet(16'd9);
    // packet ends inside a header
    packet_bytes = {8'h01, 8'h02, 8'h00, 8'h03};
    send_packet(16'd100);

    while (bytes_sent < 300) begin
      plen = build_random_packet();
      send_packet(plen);
    end

    sender_idle_pct = 65;
    receiver_stall_pct = 6;
    while (bytes_sent < 575) begin
      plen = build_random_packet();
      send_packet(plen);
    end

    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    hold_request = 300;
    while (bytes_sent < 850) begin
      plen = build_random_packet();
      send_packet(plen);
    end

    in_valid <= 1'b0;
    while (results_pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (error_count == 0 && results_pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
